// File: sv/lrwc_pkg.sv
// ----------------------------------------------------------------------------
// lrwc_pkg: shared types and constants for the lattice walk coverage block
// Lattice size, word layouts, request codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lrwc_pkg;

  // lattice and walker storage
  localparam int GRID_DIM       = 64;
  localparam int MAX_WALKERS    = 4096;
  localparam int COORD_W        = 6;
  localparam int WALKER_W       = 12;
  localparam int LATTICE_POINTS = GRID_DIM * GRID_DIM * GRID_DIM;
  // visited map is held as one row of GRID_DIM bits per (z, y) pair
  localparam int VIS_ROWS       = GRID_DIM * GRID_DIM;
  localparam int VIS_ROW_W      = $clog2(VIS_ROWS);

  // field widths
  localparam int REQ_W      = 2;
  localparam int AXIS_W     = 2;
  localparam int COUNT_W    = 13;
  localparam int PCT_W      = 7;
  localparam int STEPS_W    = 16;
  localparam int COVERED_W  = 19;
  localparam int PROD_W     = COVERED_W + PCT_W;
  localparam int PCT_SCALE  = 100;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_CELL_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_PCT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STEPS  = 2'd2;

  // stream word widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BURN  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COVER = 2'd2;

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } pos_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOVE,
    ST_MARK,
    ST_EVAL,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic move;
    logic mark;
    logic eval;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } status_t;

endpackage

// File: sv/lrwc_ctrl.sv
// ----------------------------------------------------------------------------
// lrwc_ctrl: sequencing controller
// Runs the clearing pass after reset, then walks each word through move,
// mark, evaluate and output steps, one word at a time.
// ----------------------------------------------------------------------------
module lrwc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lrwc_pkg::status_t  status,
  output lrwc_pkg::cmd_t     cmd
);
  import lrwc_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = ST_MOVE;
      end
      ST_MOVE: state_next = ST_MARK;
      ST_MARK: state_next = ST_EVAL;
      ST_EVAL: state_next = ST_OUT;
      ST_OUT: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_MOVE:  cmd.move = 1'b1;
      ST_MARK:  cmd.mark = 1'b1;
      ST_EVAL:  cmd.eval = 1'b1;
      ST_OUT:   cmd.load_out = status.out_free;
      default:  cmd = '0;
    endcase
  end

  // no word taken while the visited map is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ready)
    else $error("word accepted during clearing pass");

  // one step of the item sequence is commanded at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.accept, cmd.move, cmd.mark, cmd.eval, cmd.load_out}))
    else $error("overlapping datapath commands");

  // an accepted word always runs through the move step next
  a_accept_then_move: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.move)
    else $error("accept not followed by move step");

endmodule

// File: sv/lrwc_datapath.sv
// ----------------------------------------------------------------------------
// lrwc_datapath: walker store, visited map, counters and result register
// Holds configuration, the position memory, the visited bit map in rows,
// the covered and step counters, the finish flags and the output word.
// ----------------------------------------------------------------------------
module lrwc_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  lrwc_pkg::cmd_t                    cmd,
  output lrwc_pkg::status_t                 status,
  input  logic [lrwc_pkg::IN_DATA_W-1:0]    in_data,
  input  logic [lrwc_pkg::REQ_W-1:0]        in_req,
  input  logic                              in_last,
  input  logic                              cfg_valid,
  input  logic [lrwc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lrwc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lrwc_pkg::OUT_DATA_W-1:0]   out_data
);
  import lrwc_pkg::*;

  // configuration registers
  logic [COUNT_W-1:0] cell_count;
  logic [PCT_W-1:0]   target_percent;
  logic [STEPS_W-1:0] step_limit;

  // memories
  pos_t               pos_mem [MAX_WALKERS];
  logic [GRID_DIM-1:0] vis_mem [VIS_ROWS];

  // item registers
  logic [REQ_W-1:0]    it_req;
  logic [WALKER_W-1:0] it_walker;
  pos_t                it_load;
  logic [AXIS_W-1:0]   it_axis;
  logic                it_up;
  logic                it_eos;
  logic                it_valid;

  pos_t                pos_rd;
  pos_t                cur_pos;
  logic [GRID_DIM-1:0] vis_rd;
  logic                cover_act;
  logic                newly;

  // status
  logic [VIS_ROW_W-1:0] clr_addr;
  logic [COVERED_W-1:0] covered;
  logic [STEPS_W-1:0]   step_counter;
  logic                 target_reached;
  logic                 run_done;

  logic [VIS_ROW_W-1:0] cur_row;
  logic                 do_load;
  logic                 do_move;
  logic                 do_cover;
  pos_t                 stepped;
  pos_t                 nxt_pos;
  logic [STEPS_W-1:0]   step_inc;
  logic [PROD_W-1:0]    cov_scaled;
  logic [PROD_W-1:0]    tgt_scaled;
  logic                 hit;

  // one position along the torus
  function automatic logic [COORD_W-1:0] step_coord(input logic [COORD_W-1:0] c,
                                                    input logic up);
    logic [COORD_W-1:0] r;
    if (up) begin
      r = (c == COORD_W'(GRID_DIM - 1)) ? '0 : c + 1'b1;
    end else begin
      r = (c == '0) ? COORD_W'(GRID_DIM - 1) : c - 1'b1;
    end
    return r;
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count     <= COUNT_W'(MAX_WALKERS);
      target_percent <= PCT_W'(40);
      step_limit     <= STEPS_W'(1000);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CELL_COUNT: cell_count     <= cfg_data[COUNT_W-1:0];
        CFG_TARGET_PCT: target_percent <= cfg_data[PCT_W-1:0];
        CFG_MAX_STEPS:  step_limit     <= cfg_data[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  // capture the word and start the position read
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      it_req    <= in_req;
      it_walker <= in_data[WALKER_W-1:0];
      it_load.x <= in_data[WALKER_W +: COORD_W];
      it_load.y <= in_data[WALKER_W + COORD_W +: COORD_W];
      it_load.z <= in_data[WALKER_W + 2*COORD_W +: COORD_W];
      it_axis   <= in_data[WALKER_W + 3*COORD_W +: AXIS_W];
      it_up     <= in_data[WALKER_W + 3*COORD_W + AXIS_W];
      it_eos    <= in_last;
      it_valid  <= ({1'b0, in_data[WALKER_W-1:0]} < cell_count);
      pos_rd    <= pos_mem[in_data[WALKER_W-1:0]];
    end
  end

  // decode and step
  always_comb begin
    do_load  = it_valid && (it_req == REQ_LOAD);
    do_cover = it_valid && (it_req == REQ_COVER) && !run_done;
    do_move  = (it_valid && (it_req == REQ_BURN)) || do_cover;
    stepped  = pos_rd;
    case (it_axis)
      AXIS_X:  stepped.x = step_coord(pos_rd.x, it_up);
      AXIS_Y:  stepped.y = step_coord(pos_rd.y, it_up);
      AXIS_Z:  stepped.z = step_coord(pos_rd.z, it_up);
      default: stepped = pos_rd;
    endcase
    if (do_load) begin
      nxt_pos = it_load;
    end else if (do_move) begin
      nxt_pos = stepped;
    end else begin
      nxt_pos = pos_rd;
    end
  end

  // move step: write back position, read visited row
  always_ff @(posedge clk) begin
    if (cmd.move) begin
      cur_pos   <= nxt_pos;
      cover_act <= do_cover;
      vis_rd    <= vis_mem[{nxt_pos.z, nxt_pos.y}];
      if (do_load || do_move) pos_mem[it_walker] <= nxt_pos;
    end
  end

  assign cur_row = {cur_pos.z, cur_pos.y};

  // visited map writes: clearing pass or marking
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      vis_mem[clr_addr] <= '0;
    end else if (cmd.mark && cover_act && !vis_rd[cur_pos.x]) begin
      vis_mem[cur_row] <= vis_rd | (GRID_DIM'(1) << cur_pos.x);
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // newly covered flag for the current word
  always_ff @(posedge clk) begin
    if (cmd.move) begin
      newly <= 1'b0;
    end else if (cmd.mark) begin
      newly <= cover_act && !vis_rd[cur_pos.x];
    end
  end

  // step end arithmetic
  always_comb begin
    step_inc   = (step_counter == '1) ? step_counter : step_counter + 1'b1;
    cov_scaled = PROD_W'(covered) * PROD_W'(PCT_SCALE);
    tgt_scaled = PROD_W'(target_percent) * PROD_W'(LATTICE_POINTS);
    hit        = (cov_scaled >= tgt_scaled);
  end

  // counters and finish flags
  always_ff @(posedge clk) begin
    if (rst) begin
      covered        <= '0;
      step_counter   <= '0;
      target_reached <= 1'b0;
      run_done       <= 1'b0;
    end else begin
      if (cmd.mark && cover_act && !vis_rd[cur_pos.x]) begin
        covered <= covered + 1'b1;
      end
      if (cmd.eval && cover_act && it_eos) begin
        step_counter   <= step_inc;
        target_reached <= target_reached || hit;
        run_done       <= run_done || target_reached || hit || (step_inc >= step_limit);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {run_done, target_reached, step_counter, covered, newly,
                   it_valid ? cur_pos : pos_t'('0)};
    end
  end

  assign status.clear_last = (clr_addr == '1);
  assign status.out_free   = !out_valid || out_ready;

  // covered count never passes the lattice size
  a_cov_max: assert property (@(posedge clk) disable iff (rst)
    covered <= COVERED_W'(LATTICE_POINTS))
    else $error("covered count beyond lattice size");

  // a new mark only comes from an active coverage move
  a_newly_cover: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && newly) |-> cover_act)
    else $error("new mark without coverage move");

  // the step count moves only in the evaluate step
  a_step_eval: assert property (@(posedge clk) disable iff (rst)
    !cmd.eval |=> $stable(step_counter))
    else $error("step count changed outside evaluate");

  // target reached always finishes the run
  a_target_done: assert property (@(posedge clk) disable iff (rst)
    target_reached |-> run_done)
    else $error("target reached without run done");

endmodule

// File: sv/lattice_random_walk_coverage_top.sv
// ----------------------------------------------------------------------------
// lattice_random_walk_coverage_top: random walk coverage of a wrapped lattice
// Order: each accepted word runs through the move, mark, evaluate and output
// steps, read-modify-writes of the position memory and then the visited row
// memory; the next word is taken only after the last result is loaded.
// Reset: synchronous; clears counters and flags, then a clearing pass wipes
// the visited map row by row, during which no word is accepted.
// ----------------------------------------------------------------------------
module lattice_random_walk_coverage_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // walker[11:0], load_x[17:12], load_y[23:18], load_z[29:24], axis[31:30],
  // dir_up[32], zero fill[39:33]
  input  logic [lrwc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type[1:0]
  input  logic [lrwc_pkg::REQ_W-1:0]        s_axis_tuser,
  // end_of_step
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pos_x[5:0], pos_y[11:6], pos_z[17:12], newly_covered[18],
  // covered_total[37:19], steps_done[53:38], target_reached[54], run_done[55]
  output logic [lrwc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrwc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lrwc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lrwc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  lrwc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lrwc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_req    (s_axis_tuser),
    .in_last   (s_axis_tlast),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the wrapped lattice random walk block
// Drives load, burn-in and coverage words with random gaps and back-pressure,
// predicts every status word in a behavioural copy of the walker memory,
// visited map, counters and flags, and checks each output word field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import lrwc_pkg::*;

  // codes the package leaves unnamed
  localparam logic [REQ_W-1:0]  REQ_NONE  = 2'd3;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  localparam int     IDLE_PCT      = 37;
  localparam int     STALL_CYCLES  = 300;
  localparam int     SETTLE_CYCLES = 10;
  localparam longint LIMIT_NS      = 5_000_000;

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [WALKER_W-1:0] walker;
    pos_t                load;
    logic [AXIS_W-1:0]   axis;
    logic                up;
    logic                eos;
  } walk_req_t;

  // laid out as the output word, msb first
  typedef struct packed {
    logic                 done;
    logic                 reached;
    logic [STEPS_W-1:0]   steps;
    logic [COVERED_W-1:0] covered;
    logic                 newly;
    pos_t                 pos;
  } walk_res_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic [REQ_W-1:0]       s_axis_tuser = '0;
  logic                   s_axis_tlast = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  lattice_random_walk_coverage_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // behavioural copy of the block state and registers
  pos_t                 pos_mem [MAX_WALKERS];
  bit                   known_walker [MAX_WALKERS];
  int                   loaded_ids [$];
  bit                   visited [LATTICE_POINTS];
  logic [COVERED_W-1:0] covered_cnt = '0;
  logic [STEPS_W-1:0]   step_cnt = '0;
  logic                 reached_f = 1'b0;
  logic                 done_f = 1'b0;
  logic [COUNT_W-1:0]   cell_cnt = 13'd4096;
  logic [PCT_W-1:0]     target_pct = 7'd40;
  logic [STEPS_W-1:0]   step_limit = 16'd1000;

  walk_res_t pending_status [$];
  int        mismatch_count = 0;
  int        words_sent = 0;
  bit        tx_gaps = 1'b1;
  logic      rx_quiet = 1'b0;
  logic      stall_req = 1'b0;
  int        stall_left = 0;

  // status word that one accepted input word causes
  function automatic walk_res_t predict_walk_step(walk_req_t r);
    walk_res_t res;
    pos_t p;
    logic [3*COORD_W-1:0] idx;
    res = '0;
    if ({1'b0, r.walker} < cell_cnt) begin
      p = pos_mem[r.walker];
      if (r.req == REQ_LOAD) begin
        p = r.load;
        if (!known_walker[r.walker]) begin
          known_walker[r.walker] = 1'b1;
          loaded_ids.insert(loaded_ids.size(), r.walker);
        end
      end else if (r.req == REQ_BURN || (r.req == REQ_COVER && !done_f)) begin
        // grid edge is a power of two so the 6-bit wrap is the torus wrap
        case (r.axis)
          AXIS_X: p.x = r.up ? p.x + 1'b1 : p.x - 1'b1;
          AXIS_Y: p.y = r.up ? p.y + 1'b1 : p.y - 1'b1;
          AXIS_Z: p.z = r.up ? p.z + 1'b1 : p.z - 1'b1;
          default: ;
        endcase
        if (r.req == REQ_COVER) begin
          idx = {p.z, p.y, p.x};
          if (!visited[idx]) begin
            visited[idx] = 1'b1;
            covered_cnt++;
            res.newly = 1'b1;
          end
          if (r.eos) begin
            if (step_cnt != '1) step_cnt++;
            if (longint'(covered_cnt) * PCT_SCALE >= longint'(target_pct) * LATTICE_POINTS)
              reached_f = 1'b1;
            if (reached_f || step_cnt >= step_limit) done_f = 1'b1;
          end
        end
      end
      pos_mem[r.walker] = p;
      res.pos = p;
    end
    res.covered = covered_cnt;
    res.steps   = step_cnt;
    res.reached = reached_f;
    res.done    = done_f;
    return res;
  endfunction

  // receiver: random ready, quiet stretches and one long hold-off on request
  always @(posedge clk) begin
    if (stall_req) begin
      stall_left    <= STALL_CYCLES;
      stall_req     <= 1'b0;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each output word with the oldest prediction
  always @(posedge clk) begin : status_check
    walk_res_t got;
    walk_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected output word, expected none, got %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("pos_x", want.pos.x, got.pos.x);
        check_field("pos_y", want.pos.y, got.pos.y);
        check_field("pos_z", want.pos.z, got.pos.z);
        check_field("newly_covered", want.newly, got.newly);
        check_field("covered_total", want.covered, got.covered);
        check_field("steps_done", want.steps, got.steps);
        check_field("target_reached", want.reached, got.reached);
        check_field("run_done", want.done, got.done);
      end
    end
  end

  // offer one word, wait for the handshake, then record its prediction
  task automatic send_word(walk_req_t r);
    if (tx_gaps) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W-33){1'b0}}, r.up, r.axis, r.load, r.walker};
    s_axis_tuser  <= r.req;
    s_axis_tlast  <= r.eos;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_status.insert(pending_status.size(), predict_walk_step(r));
    words_sent++;
  endtask

  // stop offering until every predicted word is back, then let the block settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CELL_COUNT: cell_cnt   = value[COUNT_W-1:0];
      CFG_TARGET_PCT: target_pct = value[PCT_W-1:0];
      CFG_MAX_STEPS:  step_limit = value[STEPS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic walk_req_t mk_req(logic [REQ_W-1:0] req, int w, int x, int y, int z,
                                       logic [AXIS_W-1:0] axis, bit up, bit eos);
    walk_req_t r;
    r.req    = req;
    r.walker = w[WALKER_W-1:0];
    r.load.x = x[COORD_W-1:0];
    r.load.y = y[COORD_W-1:0];
    r.load.z = z[COORD_W-1:0];
    r.axis   = axis;
    r.up     = up;
    r.eos    = eos;
    return r;
  endfunction

  function automatic logic [AXIS_W-1:0] rand_axis();
    if ($urandom_range(15) == 0) return AXIS_NONE;
    return AXIS_W'($urandom_range(2));
  endfunction

  // a loaded walker inside the current count; walker 0 is always loaded
  function automatic int pick_walker();
    int w;
    repeat (8) begin
      w = loaded_ids[$urandom_range(loaded_ids.size() - 1)];
      if (w < cell_cnt) return w;
    end
    return 0;
  endfunction

  task automatic send_move(logic [REQ_W-1:0] req, bit eos);
    send_word(mk_req(req, pick_walker(), $urandom_range(63), $urandom_range(63),
                     $urandom_range(63), rand_axis(), $urandom_range(1), eos));
  endtask

  task automatic send_load();
    send_word(mk_req(REQ_LOAD, $urandom_range(cell_cnt - 1), $urandom_range(63),
                     $urandom_range(63), $urandom_range(63), rand_axis(),
                     $urandom_range(1), $urandom_range(1)));
  endtask

  // any field values, but never a move or read of a walker that was never loaded
  task automatic send_noise();
    walk_req_t r;
    r = mk_req(REQ_W'($urandom_range(3)), $urandom_range(MAX_WALKERS - 1),
               $urandom_range(63), $urandom_range(63), $urandom_range(63),
               AXIS_W'($urandom_range(3)), $urandom_range(1), $urandom_range(1));
    if ({1'b0, r.walker} < cell_cnt && !known_walker[r.walker] && r.req != REQ_LOAD)
      r.req = REQ_LOAD;
    send_word(r);
  endtask

  // mostly whole coverage steps, some burn-in runs, loads and noise
  task automatic run_random(int n);
    int start;
    int pick;
    int len;
    start = words_sent;
    while (words_sent - start < n) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) send_move(REQ_COVER, i == len - 1);
      end else if (pick < 72) begin
        len = $urandom_range(1, 4);
        repeat (len) send_move(REQ_BURN, $urandom_range(1));
      end else if (pick < 85) begin
        send_load();
      end else begin
        send_noise();
      end
    end
  endtask

  // corners of the lattice, wrap on both x and y faces, every request kind
  task automatic test_directed();
    write_reg(CFG_CELL_COUNT, 16'd4096);
    write_reg(CFG_TARGET_PCT, 16'd127);
    write_reg(CFG_MAX_STEPS, 16'd65535);
    send_word(mk_req(REQ_LOAD, 0, 0, 0, 0, AXIS_X, 0, 0));
    send_word(mk_req(REQ_LOAD, 4095, 63, 63, 63, AXIS_NONE, 1, 1));
    send_word(mk_req(REQ_LOAD, 2730, 21, 42, 63, AXIS_Y, 0, 0));
    send_word(mk_req(REQ_BURN, 4095, 0, 0, 0, AXIS_X, 1, 0));
    send_word(mk_req(REQ_BURN, 4095, 0, 0, 0, AXIS_Y, 1, 0));
    send_word(mk_req(REQ_BURN, 4095, 0, 0, 0, AXIS_Z, 0, 0));
    send_word(mk_req(REQ_BURN, 0, 0, 0, 0, AXIS_X, 0, 0));
    send_word(mk_req(REQ_BURN, 0, 0, 0, 0, AXIS_Y, 0, 1));
    send_word(mk_req(REQ_BURN, 0, 0, 0, 0, AXIS_Z, 1, 0));
    // no-axis coverage move marks the point it stands on, twice
    send_word(mk_req(REQ_COVER, 0, 0, 0, 0, AXIS_NONE, 1, 0));
    send_word(mk_req(REQ_COVER, 0, 0, 0, 0, AXIS_NONE, 0, 0));
    send_word(mk_req(REQ_COVER, 0, 0, 0, 0, AXIS_X, 1, 0));
    send_word(mk_req(REQ_COVER, 4095, 0, 0, 0, AXIS_Z, 1, 1));
    send_word(mk_req(REQ_NONE, 2730, 63, 63, 63, AXIS_X, 1, 1));
    send_word(mk_req(REQ_BURN, 0, 0, 0, 0, AXIS_NONE, 1, 0));
    send_word(mk_req(REQ_COVER, 2730, 0, 0, 0, AXIS_X, 0, 1));
    send_word(mk_req(REQ_LOAD, 0, 5, 6, 7, AXIS_Z, 1, 0));
  endtask

  // walkers at or above the count are ignored whatever the request
  task automatic test_walker_range();
    write_reg(CFG_CELL_COUNT, 16'd3);
    send_word(mk_req(REQ_LOAD, 5, 9, 9, 9, AXIS_X, 0, 0));
    send_word(mk_req(REQ_COVER, 4095, 0, 0, 0, AXIS_X, 1, 1));
    send_word(mk_req(REQ_LOAD, 2, 1, 2, 3, AXIS_X, 0, 0));
    send_word(mk_req(REQ_COVER, 2, 0, 0, 0, AXIS_Y, 0, 1));
    send_word(mk_req(REQ_NONE, 3, 0, 0, 0, AXIS_X, 0, 0));
    send_word(mk_req(REQ_BURN, 0, 0, 0, 0, AXIS_Z, 0, 1));
  endtask

  // full walker range, unreachable target, one long output hold-off
  task automatic test_full_walk();
    write_reg(CFG_CELL_COUNT, 16'd4096);
    write_reg(CFG_TARGET_PCT, 16'd100);
    run_random(400);
    stall_req <= 1'b1;
    run_random(150);
    run_random(200);
  endtask

  task automatic test_single_walker();
    write_reg(CFG_CELL_COUNT, 16'd1);
    write_reg(CFG_TARGET_PCT, 16'd127);
    run_random(150);
  endtask

  // mid-range settings, a gap-free stretch and a full drain mid-stream
  task automatic test_mixed_settings();
    int limit;
    limit = step_cnt + 3000;
    if (limit > 65535) limit = 65535;
    write_reg(CFG_CELL_COUNT, CFG_DATA_W'($urandom_range(2, 4095)));
    write_reg(CFG_TARGET_PCT, CFG_DATA_W'($urandom_range(50, 99)));
    write_reg(CFG_MAX_STEPS, CFG_DATA_W'(limit));
    run_random(200);
    tx_gaps = 1'b0;
    rx_quiet <= 1'b1;
    run_random(150);
    tx_gaps = 1'b1;
    rx_quiet <= 1'b0;
    drain_results();
    run_random(150);
  endtask

  // end the run either by the step limit or by a zero target
  task automatic test_finish();
    write_reg(CFG_CELL_COUNT, 16'd4096);
    if ($urandom_range(1) == 0) begin
      write_reg(CFG_MAX_STEPS, 16'd0);
    end else begin
      write_reg(CFG_MAX_STEPS, 16'd65535);
      write_reg(CFG_TARGET_PCT, 16'd0);
    end
    run_random(250);
  endtask

  // finished run: coverage moves frozen, loads and burn-in still act
  task automatic test_after_finish();
    write_reg(CFG_CELL_COUNT, CFG_DATA_W'($urandom_range(1, 4096)));
    run_random(150);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_walker_range();
    test_full_walk();
    test_single_walker();
    test_mixed_settings();
    test_finish();
    test_after_finish();
    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: lattice_random_walk_coverage_top.f
sv/lrwc_pkg.sv
sv/lrwc_ctrl.sv
sv/lrwc_datapath.sv
sv/lattice_random_walk_coverage_top.sv
tb/tb_top.sv
